/* design/xm1k_pkg.sv */
// Package: character codes, operation, phase and error codes, frame sizes and the CRC step for the sender.
`timescale 1ns / 1ps

package xm1k_pkg;

    // Packet geometry
    localparam int PACKET_BYTES = 1024;
    localparam int ADDR_W       = $clog2(PACKET_BYTES);
    localparam int CNT_W        = $clog2(PACKET_BYTES + 6);

    localparam logic [CNT_W-1:0] HDR_BYTES  = CNT_W'(3);
    localparam logic [CNT_W-1:0] DATA_END   = CNT_W'(3 + PACKET_BYTES);
    localparam logic [CNT_W-1:0] FRAME_CRC  = CNT_W'(3 + PACKET_BYTES + 2);
    localparam logic [CNT_W-1:0] FRAME_SUM  = CNT_W'(3 + PACKET_BYTES + 1);
    localparam logic [CNT_W-1:0] STORE_FULL = CNT_W'(PACKET_BYTES);

    // Line characters
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_SUB = 8'h1A;
    localparam logic [7:0] CH_C   = 8'h43;

    // Operation codes
    localparam logic [2:0] OP_LOAD    = 3'd0;
    localparam logic [2:0] OP_PULL    = 3'd1;
    localparam logic [2:0] OP_RX      = 3'd2;
    localparam logic [2:0] OP_TIMEOUT = 3'd3;
    localparam logic [2:0] OP_ABORT   = 3'd4;

    // Phase codes
    localparam logic [2:0] PH_SYNC = 3'd0;
    localparam logic [2:0] PH_LOAD = 3'd1;
    localparam logic [2:0] PH_SEND = 3'd2;
    localparam logic [2:0] PH_WAIT = 3'd3;
    localparam logic [2:0] PH_EOT  = 3'd4;
    localparam logic [2:0] PH_DONE = 3'd5;
    localparam logic [2:0] PH_FAIL = 3'd6;

    // Error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_CANCEL   = 3'd1;
    localparam logic [2:0] ERR_NO_SYNC  = 3'd2;
    localparam logic [2:0] ERR_PACKET   = 3'd3;
    localparam logic [2:0] ERR_NO_EOTACK = 3'd4;
    localparam logic [2:0] ERR_ABORT    = 3'd5;

    localparam logic [7:0]  MAX_ATTEMPTS_RST = 8'd10;
    localparam logic [15:0] CRC_POLY         = 16'h1021;

    // CRC-16-CCITT, MSB first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* design/xmodem_1k_sender.sv */
// Top level: XMODEM-1K sender with a packet store of one write and one read port and byte-wise frame output.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                      Content
// s_axis    in         s_axis_tvalid / s_axis_tready  operation, data_byte, end_of_file
// m_axis    out        m_axis_tvalid / m_axis_tready  tx_valid, tx_byte, tx_last, status
// cfg       in         cfg_valid / cfg_ready          max_attempts
//
// Each item goes through the packet store read (registered data) when it is taken,
// then the state update and the load of the output register.
// The next item is taken while a result waits; its update waits for m_axis_tready.
// Reset clears all control state but not the captured item; the packet store is not cleared,
// only entries loaded for the current packet are ever used.
module xmodem_1k_sender
    import xm1k_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [2:0]  s_axis_tuser,   // [2:0] operation
    input  logic        s_axis_tlast,   // end_of_file
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] tx_byte, [10:8] phase,
                                        // [13:11] error_code, [21:14] block_number
    output logic        m_axis_tuser,   // tx_valid
    output logic        m_axis_tlast,   // tx_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data        // max_attempts
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         op_reg;
    logic [7:0]         db_reg;
    logic               eof_reg;

    logic [CNT_W-1:0]   load_count_reg, load_count_next;
    logic [CNT_W-1:0]   send_index_reg, send_index_next;
    logic [7:0]         seq_reg, seq_next;
    logic [15:0]        crc_reg, crc_next;
    logic [7:0]         sum_reg, sum_next;
    logic               use_crc_reg, use_crc_next;
    logic [7:0]         attempt_reg, attempt_next;
    logic [2:0]         phase_reg, phase_next;
    logic               final_reg, final_next;
    logic [1:0]         etx_reg, etx_next;
    logic [2:0]         error_reg, error_next;
    logic [7:0]         max_attempts_reg;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               out_tv_reg, out_tv_next;
    logic               out_tl_reg, out_tl_next;

    logic               accept;
    logic               commit;
    logic               rd_en;
    logic               wr_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [7:0]         mem_q;
    logic [7:0]         store [PACKET_BYTES];

    logic [CNT_W-1:0]   data_pos;
    logic [CNT_W-1:0]   idx_inc;
    logic [7:0]         data_byte;
    logic [7:0]         attempt_inc;
    logic               exhausted;
    logic               is_rx;
    logic               is_rx_or_to;

    // Handshakes
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign commit        = (state_reg == ST_EXEC) && (!out_valid_reg || m_axis_tready);

    // Store read address follows the frame position of the next pull
    assign rd_en   = accept;
    assign rd_addr = ADDR_W'(send_index_reg - HDR_BYTES);
    assign wr_en   = commit && (phase_reg == PH_LOAD) && (op_reg == OP_LOAD)
                     && (load_count_reg < STORE_FULL);

    // Packet store, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store[load_count_reg[ADDR_W-1:0]] <= db_reg;
        if (rd_en)
            mem_q <= store[rd_addr];
    end

    // Data byte for the current frame position, with CTRLZ and zero padding
    assign data_pos    = send_index_reg - HDR_BYTES;
    assign data_byte   = (data_pos < load_count_reg) ? mem_q :
                         (data_pos == load_count_reg) ? CH_SUB : 8'h00;
    assign idx_inc     = send_index_reg + CNT_W'(1);
    assign attempt_inc = (attempt_reg != 8'hFF) ? attempt_reg + 8'd1 : attempt_reg;
    assign exhausted   = (attempt_inc >= max_attempts_reg);
    assign is_rx       = (op_reg == OP_RX);
    assign is_rx_or_to = is_rx || (op_reg == OP_TIMEOUT);

    // Protocol step
    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        send_index_next = send_index_reg;
        seq_next        = seq_reg;
        crc_next        = crc_reg;
        sum_next        = sum_reg;
        use_crc_next    = use_crc_reg;
        attempt_next    = attempt_reg;
        phase_next      = phase_reg;
        final_next      = final_reg;
        etx_next        = etx_reg;
        error_next      = error_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_byte_next   = out_byte_reg;
        out_tv_next     = out_tv_reg;
        out_tl_next     = out_tl_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_byte_next  = 8'h00;
                    out_tv_next    = 1'b0;
                    out_tl_next    = 1'b0;

                    if (op_reg == OP_ABORT && phase_reg <= PH_EOT)
                    begin
                        phase_next = PH_FAIL;
                        error_next = ERR_ABORT;
                        etx_next   = 2'd3;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_SYNC:
                            begin
                                if (is_rx && (db_reg inside {CH_C, CH_NAK}))
                                begin
                                    use_crc_next    = (db_reg == CH_C);
                                    attempt_next    = 8'd0;
                                    phase_next      = PH_LOAD;
                                    load_count_next = '0;
                                end
                                else if (is_rx && db_reg == CH_CAN)
                                begin
                                    phase_next = PH_FAIL;
                                    error_next = ERR_CANCEL;
                                    etx_next   = 2'd3;
                                end
                                else if (is_rx_or_to)
                                begin
                                    attempt_next = attempt_inc;
                                    if (exhausted)
                                    begin
                                        phase_next = PH_FAIL;
                                        error_next = ERR_NO_SYNC;
                                        etx_next   = 2'd3;
                                    end
                                end
                            end
                            PH_LOAD:
                            begin
                                if (op_reg == OP_LOAD)
                                begin
                                    if (load_count_reg < STORE_FULL)
                                        load_count_next = load_count_reg + CNT_W'(1);
                                    if (eof_reg || load_count_next >= STORE_FULL)
                                    begin
                                        final_next      = eof_reg;
                                        attempt_next    = 8'd0;
                                        phase_next      = PH_SEND;
                                        send_index_next = '0;
                                        crc_next        = 16'h0000;
                                        sum_next        = 8'h00;
                                    end
                                end
                            end
                            PH_SEND:
                            begin
                                if (op_reg == OP_PULL)
                                begin
                                    if (send_index_reg == CNT_W'(0))
                                        out_byte_next = CH_STX;
                                    else if (send_index_reg == CNT_W'(1))
                                        out_byte_next = seq_reg;
                                    else if (send_index_reg == CNT_W'(2))
                                        out_byte_next = ~seq_reg;
                                    else if (send_index_reg < DATA_END)
                                    begin
                                        out_byte_next = data_byte;
                                        crc_next      = crc_byte(crc_reg, data_byte);
                                        sum_next      = sum_reg + data_byte;
                                    end
                                    else if (use_crc_reg)
                                        out_byte_next = (send_index_reg == DATA_END) ?
                                                        crc_reg[15:8] : crc_reg[7:0];
                                    else
                                        out_byte_next = sum_reg;
                                    out_tv_next     = 1'b1;
                                    send_index_next = idx_inc;
                                    if (idx_inc >= (use_crc_reg ? FRAME_CRC : FRAME_SUM))
                                    begin
                                        out_tl_next = 1'b1;
                                        phase_next  = PH_WAIT;
                                    end
                                end
                            end
                            PH_WAIT:
                            begin
                                if (is_rx && db_reg == CH_ACK)
                                begin
                                    seq_next     = seq_reg + 8'd1;
                                    attempt_next = 8'd0;
                                    if (final_reg)
                                    begin
                                        phase_next      = PH_EOT;
                                        send_index_next = '0;
                                    end
                                    else
                                    begin
                                        phase_next      = PH_LOAD;
                                        load_count_next = '0;
                                    end
                                end
                                else if (is_rx && db_reg == CH_CAN)
                                begin
                                    phase_next = PH_FAIL;
                                    error_next = ERR_CANCEL;
                                    etx_next   = 2'd3;
                                end
                                else if (is_rx_or_to)
                                begin
                                    attempt_next = attempt_inc;
                                    if (exhausted)
                                    begin
                                        phase_next = PH_FAIL;
                                        error_next = ERR_PACKET;
                                        etx_next   = 2'd3;
                                    end
                                    else
                                    begin
                                        phase_next      = PH_SEND;
                                        send_index_next = '0;
                                        crc_next        = 16'h0000;
                                        sum_next        = 8'h00;
                                    end
                                end
                            end
                            PH_EOT:
                            begin
                                if (send_index_reg == CNT_W'(0))
                                begin
                                    if (op_reg == OP_PULL)
                                    begin
                                        out_tv_next     = 1'b1;
                                        out_tl_next     = 1'b1;
                                        out_byte_next   = CH_EOT;
                                        send_index_next = CNT_W'(1);
                                    end
                                end
                                else if (is_rx && db_reg == CH_ACK)
                                    phase_next = PH_DONE;
                                else if (is_rx_or_to)
                                begin
                                    attempt_next = attempt_inc;
                                    if (exhausted)
                                    begin
                                        phase_next = PH_FAIL;
                                        error_next = ERR_NO_EOTACK;
                                        etx_next   = 2'd3;
                                    end
                                    else
                                        send_index_next = '0;
                                end
                            end
                            PH_FAIL:
                            begin
                                if (op_reg == OP_PULL && etx_reg != 2'd0)
                                begin
                                    etx_next      = etx_reg - 2'd1;
                                    out_tv_next   = 1'b1;
                                    out_byte_next = CH_ETX;
                                    out_tl_next   = (etx_reg == 2'd1);
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // State and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            load_count_reg   <= '0;
            send_index_reg   <= '0;
            seq_reg          <= 8'd1;
            crc_reg          <= 16'h0000;
            sum_reg          <= 8'h00;
            use_crc_reg      <= 1'b0;
            attempt_reg      <= 8'd0;
            phase_reg        <= PH_SYNC;
            final_reg        <= 1'b0;
            etx_reg          <= 2'd0;
            error_reg        <= ERR_NONE;
            max_attempts_reg <= MAX_ATTEMPTS_RST;
            out_valid_reg    <= 1'b0;
            out_byte_reg     <= 8'h00;
            out_tv_reg       <= 1'b0;
            out_tl_reg       <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            load_count_reg   <= load_count_next;
            send_index_reg   <= send_index_next;
            seq_reg          <= seq_next;
            crc_reg          <= crc_next;
            sum_reg          <= sum_next;
            use_crc_reg      <= use_crc_next;
            attempt_reg      <= attempt_next;
            phase_reg        <= phase_next;
            final_reg        <= final_next;
            etx_reg          <= etx_next;
            error_reg        <= error_next;
            out_valid_reg    <= out_valid_next;
            out_byte_reg     <= out_byte_next;
            out_tv_reg       <= out_tv_next;
            out_tl_reg       <= out_tl_next;
            if (cfg_valid && cfg_ready)
                max_attempts_reg <= cfg_data;
        end
    end

    // Captured item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= s_axis_tuser;
            db_reg  <= s_axis_tdata;
            eof_reg <= s_axis_tlast;
        end
    end

    // Result channel; status fields hold while the result waits
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_tv_reg;
    assign m_axis_tlast  = out_tl_reg;
    assign m_axis_tdata  = {2'b00, seq_reg, error_reg, phase_reg, out_byte_reg};

`ifndef NO_ASSERTIONS
    // A taken item is worked on before another is taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_axis_tready)
        else $error("item accepted while previous item in progress");

    // An error code is set exactly when the transfer has failed
    a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (error_reg != ERR_NONE) == (phase_reg == PH_FAIL))
        else $error("error code and failed phase disagree");

    // Frame position never runs past the longest frame
    a_send_idx: assert property (@(posedge clk) disable iff (!rst_n)
        send_index_reg <= FRAME_CRC)
        else $error("send index beyond frame");

    // Load count never runs past the store
    a_load_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        load_count_reg <= STORE_FULL)
        else $error("load count beyond store");

    // A result without a line byte carries a zero byte and no last mark
    a_idle_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[7:0] == 8'h00 && !m_axis_tlast))
        else $error("byte or last set on a result with no line byte");
`endif

endmodule

/* tb/sv/xmodem_1k_sender_tb.sv */
// Testbench for the XMODEM-1K sender: protocol-shaped random transfer checked against a predictor.
`timescale 1ns / 1ps

module xmodem_1k_sender_tb;
    import xm1k_pkg::*;

    // Operation codes the block has no use for
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_ITEMS   = 24;

    // How the transfer is brought to its end in this run
    typedef enum int {
        END_DONE,
        END_CANCEL,
        END_PACKET_FAIL,
        END_EOT_FAIL,
        END_ABORT
    } finish_kind_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_last;
        logic [2:0] phase;
        logic [2:0] err;
        logic [7:0] blk;
    } line_out_t;

    typedef struct {
        logic [2:0] op;
        logic [7:0] data;
        logic       eof;
        bit         typed;
        line_out_t  want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] data_byte
    logic [2:0]  s_axis_tuser = '0;     // [2:0] operation
    logic        s_axis_tlast = 1'b0;   // end_of_file
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [7:0] tx_byte, [10:8] phase,
                                        // [13:11] error_code, [21:14] block_number
    logic        m_axis_tuser;          // tx_valid
    logic        m_axis_tlast;          // tx_last
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;         // max_attempts

    // Sender state as the predictor sees it
    logic [7:0]  store_bytes [PACKET_BYTES];
    int          loaded_count = 0;
    int          frame_pos = 0;
    logic [7:0]  seq_no = 8'd1;
    logic [15:0] crc_acc = '0;
    logic [7:0]  sum_acc = '0;
    bit          crc_mode = 1'b0;
    logic [7:0]  tries = '0;
    logic [7:0]  tries_allowed = MAX_ATTEMPTS_RST;
    logic [2:0]  cur_phase = PH_SYNC;
    logic [2:0]  cur_error = ERR_NONE;
    bit          last_packet = 1'b0;
    int          etx_left = 0;

    line_out_t   pending_lines [$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    int          idle_cycles = 0;
    bit          calm_sender = 1'b0;

    xmodem_1k_sender dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic line_out_t quiet(logic [2:0] ph, logic [2:0] er, logic [7:0] bn);
        return '{1'b0, 8'h00, 1'b0, ph, er, bn};
    endfunction

    function automatic string show(line_out_t v);
        return $sformatf("valid=%0b byte=%02h last=%0b phase=%0d error=%0d block=%02h",
                         v.tx_valid, v.tx_byte, v.tx_last, v.phase, v.err, v.blk);
    endfunction

    function automatic void enter_fail(logic [2:0] code);
        cur_phase = PH_FAIL;
        cur_error = code;
        etx_left  = 3;
    endfunction

    // Returns 1 once the attempts are used up
    function automatic bit spend_try();
        if (tries < 8'd255)
            tries++;
        return tries >= tries_allowed;
    endfunction

    function automatic void open_frame();
        cur_phase = PH_SEND;
        frame_pos = 0;
        crc_acc   = '0;
        sum_acc   = '0;
    endfunction

    // One item in, one line out; updates the sender state
    function automatic line_out_t xmodem_step(logic [2:0] op, logic [7:0] db, logic eof);
        line_out_t   r;
        logic [7:0]  b;
        logic [15:0] c;
        int          frame_len;
        r = '0;
        frame_len = PACKET_BYTES + (crc_mode ? 5 : 4);
        if (op == OP_ABORT && cur_phase <= PH_EOT)
            enter_fail(ERR_ABORT);
        else
        begin
            case (cur_phase)
                PH_SYNC:
                begin
                    if (op == OP_RX && (db inside {CH_C, CH_NAK}))
                    begin
                        crc_mode     = (db == CH_C);
                        tries        = '0;
                        cur_phase    = PH_LOAD;
                        loaded_count = 0;
                    end
                    else if (op == OP_RX && db == CH_CAN)
                        enter_fail(ERR_CANCEL);
                    else if ((op == OP_RX || op == OP_TIMEOUT) && spend_try())
                        enter_fail(ERR_NO_SYNC);
                end
                PH_LOAD:
                begin
                    if (op == OP_LOAD)
                    begin
                        if (loaded_count < PACKET_BYTES)
                        begin
                            store_bytes[loaded_count] = db;
                            loaded_count++;
                        end
                        if (eof || loaded_count >= PACKET_BYTES)
                        begin
                            last_packet = eof;
                            tries       = '0;
                            open_frame();
                        end
                    end
                end
                PH_SEND:
                begin
                    if (op == OP_PULL)
                    begin
                        if (frame_pos == 0)
                            b = CH_STX;
                        else if (frame_pos == 1)
                            b = seq_no;
                        else if (frame_pos == 2)
                            b = ~seq_no;
                        else if (frame_pos < PACKET_BYTES + 3)
                        begin
                            // short packet: CTRLZ after the data, zeros beyond
                            if (frame_pos - 3 < loaded_count)
                                b = store_bytes[frame_pos - 3];
                            else if (frame_pos - 3 == loaded_count)
                                b = CH_SUB;
                            else
                                b = 8'h00;
                            // CRC-16-CCITT, MSB first
                            c = crc_acc ^ {b, 8'h00};
                            for (int k = 0; k < 8; k++)
                                c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
                            crc_acc = c;
                            sum_acc = sum_acc + b;
                        end
                        else if (crc_mode)
                            b = (frame_pos == PACKET_BYTES + 3) ? crc_acc[15:8] : crc_acc[7:0];
                        else
                            b = sum_acc;
                        r.tx_valid = 1'b1;
                        r.tx_byte  = b;
                        frame_pos++;
                        if (frame_pos >= frame_len)
                        begin
                            r.tx_last = 1'b1;
                            cur_phase = PH_WAIT;
                        end
                    end
                end
                PH_WAIT:
                begin
                    if (op == OP_RX && db == CH_ACK)
                    begin
                        seq_no = seq_no + 8'd1;
                        tries  = '0;
                        if (last_packet)
                        begin
                            cur_phase = PH_EOT;
                            frame_pos = 0;
                        end
                        else
                        begin
                            cur_phase    = PH_LOAD;
                            loaded_count = 0;
                        end
                    end
                    else if (op == OP_RX && db == CH_CAN)
                        enter_fail(ERR_CANCEL);
                    else if (op == OP_RX || op == OP_TIMEOUT)
                    begin
                        if (spend_try())
                            enter_fail(ERR_PACKET);
                        else
                            open_frame();
                    end
                end
                PH_EOT:
                begin
                    // replies count only once the EOT has gone out
                    if (frame_pos == 0)
                    begin
                        if (op == OP_PULL)
                        begin
                            r.tx_valid = 1'b1;
                            r.tx_last  = 1'b1;
                            r.tx_byte  = CH_EOT;
                            frame_pos  = 1;
                        end
                    end
                    else if (op == OP_RX && db == CH_ACK)
                        cur_phase = PH_DONE;
                    else if (op == OP_RX || op == OP_TIMEOUT)
                    begin
                        if (spend_try())
                            enter_fail(ERR_NO_EOTACK);
                        else
                            frame_pos = 0;
                    end
                end
                PH_FAIL:
                begin
                    if (op == OP_PULL && etx_left > 0)
                    begin
                        etx_left--;
                        r.tx_valid = 1'b1;
                        r.tx_byte  = CH_ETX;
                        r.tx_last  = (etx_left == 0);
                    end
                end
                default:
                    ;
            endcase
        end
        r.phase = cur_phase;
        r.err   = cur_error;
        r.blk   = seq_no;
        return r;
    endfunction

    // An operation that the current phase ignores
    function automatic logic [2:0] stray_op(logic [2:0] busy_a, logic [2:0] busy_b);
        logic [2:0] op;
        do
            op = 3'($urandom_range(OP_LOAD, OP_SPARE_HI));
        while (op == busy_a || op == busy_b || op == OP_ABORT);
        return op;
    endfunction

    // A reply that asks for a resend: NAK, timeout or a stray byte
    function automatic logic [10:0] refusal();
        logic [7:0] b;
        case ($urandom_range(0, 2))
            0:       return {OP_TIMEOUT, 8'($urandom_range(0, 255))};
            1:       return {OP_RX, CH_NAK};
            default:
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_ACK || b == CH_CAN);
                return {OP_RX, b};
            end
        endcase
    endfunction

    // Offer one item, wait for its transfer and record what it should produce
    task automatic offer_item(input logic [2:0] op, input logic [7:0] data, input logic eof,
                              input bit typed, input line_out_t want);
        int        gap;
        int        pick;
        line_out_t predicted;
        gap = 0;
        if (items_sent % 400 == 0)
            calm_sender = ($urandom_range(0, 3) == 0);
        if (!calm_sender)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                gap = $urandom_range(1, 3);
            else if (pick < 24)
                gap = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        s_axis_tlast  <= eof;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = xmodem_step(op, data, eof);
        pending_lines.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Let everything drain, then write the attempt limit
    task automatic settle_and_set_tries(input logic [7:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_lines.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid     <= 1'b0;
        tries_allowed = value;
    endtask

    // Stimulus
    initial
    begin
        stim_row_t    rows [$];
        logic [7:0]   sync_char;
        finish_kind_t finish_kind;
        int           full_before;
        int           final_len;
        int           acked;
        int           retries;
        int           abort_at;
        int           tail_left;
        int           pick;
        bit           final_limit_set;
        logic [2:0]   op;
        logic [2:0]   prev_phase;
        logic [7:0]   data;
        logic         eof;

        sync_char = $urandom_range(0, 1) ? CH_C : CH_NAK;

        // Sync noise, ignored operations, then the first payload bytes
        rows.push_back('{OP_PULL,     8'h00, 1'b0, 1'b1, quiet(PH_SYNC, ERR_NONE, 8'd1)});
        rows.push_back('{OP_LOAD,     8'hFF, 1'b1, 1'b1, quiet(PH_SYNC, ERR_NONE, 8'd1)});
        rows.push_back('{OP_TIMEOUT,  8'h00, 1'b0, 1'b1, quiet(PH_SYNC, ERR_NONE, 8'd1)});
        rows.push_back('{OP_RX,       8'h00, 1'b0, 1'b1, quiet(PH_SYNC, ERR_NONE, 8'd1)});
        rows.push_back('{OP_RX,       8'hFF, 1'b1, 1'b1, quiet(PH_SYNC, ERR_NONE, 8'd1)});
        rows.push_back('{OP_RX,       CH_ACK, 1'b0, 1'b1, quiet(PH_SYNC, ERR_NONE, 8'd1)});
        rows.push_back('{OP_SPARE_LO, 8'hAA, 1'b1, 1'b1, quiet(PH_SYNC, ERR_NONE, 8'd1)});
        rows.push_back('{OP_SPARE_HI, 8'h55, 1'b0, 1'b1, quiet(PH_SYNC, ERR_NONE, 8'd1)});
        rows.push_back('{OP_RX,       sync_char, 1'b0, 1'b1, quiet(PH_LOAD, ERR_NONE, 8'd1)});
        rows.push_back('{OP_PULL,     8'h00, 1'b0, 1'b1, quiet(PH_LOAD, ERR_NONE, 8'd1)});
        rows.push_back('{OP_RX,       CH_NAK, 1'b0, 1'b1, quiet(PH_LOAD, ERR_NONE, 8'd1)});
        rows.push_back('{OP_TIMEOUT,  8'hFF, 1'b1, 1'b1, quiet(PH_LOAD, ERR_NONE, 8'd1)});
        rows.push_back('{OP_SPARE_MID, 8'h0F, 1'b1, 1'b1, quiet(PH_LOAD, ERR_NONE, 8'd1)});
        rows.push_back('{OP_LOAD,     8'h00, 1'b0, 1'b1, quiet(PH_LOAD, ERR_NONE, 8'd1)});
        rows.push_back('{OP_LOAD,     8'hFF, 1'b0, 1'b1, quiet(PH_LOAD, ERR_NONE, 8'd1)});
        rows.push_back('{OP_LOAD,     8'h80, 1'b0, 1'b1, quiet(PH_LOAD, ERR_NONE, 8'd1)});
        rows.push_back('{OP_LOAD,     8'h01, 1'b0, 1'b1, quiet(PH_LOAD, ERR_NONE, 8'd1)});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            offer_item(rows[i].op, rows[i].data, rows[i].eof, rows[i].typed, rows[i].want);
        settle_and_set_tries(8'd255);

        // Plan of the transfer: one packet, or a full one first when an abort cuts it short
        finish_kind = finish_kind_t'($urandom_range(END_DONE, END_ABORT));
        full_before = (finish_kind == END_ABORT) ? 1 : 0;
        pick = $urandom_range(0, 3);
        final_len = (pick == 0) ? PACKET_BYTES :
                    (pick == 1) ? PACKET_BYTES - 1 : $urandom_range(1, 40);
        abort_at = items_sent + $urandom_range(800, 2400);
        acked = 0;
        retries = 0;
        tail_left = TAIL_ITEMS;
        final_limit_set = 1'b0;

        while (tail_left > 0 && items_sent < 30000)
        begin
            eof  = 1'($urandom_range(0, 1));
            data = 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            prev_phase = cur_phase;
            if (finish_kind == END_ABORT && items_sent >= abort_at && cur_phase <= PH_EOT)
                op = OP_ABORT;
            else
            begin
                case (cur_phase)
                    PH_LOAD:
                    begin
                        if (pick < 6)
                            op = stray_op(OP_LOAD, OP_LOAD);
                        else
                        begin
                            op  = OP_LOAD;
                            eof = (acked == full_before) && (loaded_count + 1 == final_len);
                        end
                    end
                    PH_SEND:
                        op = (pick < 3) ? stray_op(OP_PULL, OP_PULL) : OP_PULL;
                    PH_WAIT:
                    begin
                        if (pick < 5)
                            op = stray_op(OP_RX, OP_TIMEOUT);
                        else if (last_packet && finish_kind == END_CANCEL)
                        begin
                            op   = OP_RX;
                            data = CH_CAN;
                        end
                        else if ((last_packet && finish_kind == END_PACKET_FAIL) ||
                                 (retries < 1 && int'(tries) + 1 < int'(tries_allowed) &&
                                  pick < 30))
                        begin
                            {op, data} = refusal();
                            retries++;
                        end
                        else
                        begin
                            op   = OP_RX;
                            data = CH_ACK;
                        end
                    end
                    PH_EOT:
                    begin
                        if (frame_pos == 0)
                            op = (pick < 15) ? stray_op(OP_PULL, OP_PULL) : OP_PULL;
                        else if (pick < 5)
                            op = stray_op(OP_RX, OP_TIMEOUT);
                        else if (finish_kind == END_EOT_FAIL ||
                                 (retries < 2 && int'(tries) + 1 < int'(tries_allowed) &&
                                  pick < 35))
                        begin
                            {op, data} = refusal();
                            retries++;
                        end
                        else
                        begin
                            op   = OP_RX;
                            data = CH_ACK;
                        end
                    end
                    default:
                    begin
                        // done or failed: drain the ETX burst, everything else is ignored
                        op = (pick < 50) ? OP_PULL : 3'($urandom_range(OP_LOAD, OP_SPARE_HI));
                        tail_left--;
                    end
                endcase
            end

            offer_item(op, data, eof, 1'b0, '0);

            // Attempt limit changes at packet boundaries, with the block idle
            if (prev_phase == PH_WAIT && cur_phase == PH_LOAD)
            begin
                acked++;
                retries = 0;
                settle_and_set_tries(8'($urandom_range(3, 255)));
            end
            else if (prev_phase == PH_SEND && cur_phase == PH_WAIT && last_packet &&
                     finish_kind == END_PACKET_FAIL && !final_limit_set)
            begin
                final_limit_set = 1'b1;
                settle_and_set_tries($urandom_range(0, 1) ? 8'd1 : 8'd2);
            end
            else if (prev_phase == PH_WAIT && cur_phase == PH_EOT)
            begin
                retries = 0;
                if (finish_kind == END_EOT_FAIL)
                    settle_and_set_tries(8'($urandom_range(1, 3)));
                else
                    settle_and_set_tries($urandom_range(0, 1) ? 8'd1 :
                                         8'($urandom_range(2, 255)));
            end
        end

        // Wait for the last results, then a little longer
        s_axis_tvalid <= 1'b0;
        while (pending_lines.size() != 0)
            @(posedge clk);
        repeat (2 * DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Receiver: random stalls, calm stretches and one long hold-off
    initial
    begin
        int stall_left;
        int pick;
        bit held;
        bit calm;
        stall_left = 0;
        held = 1'b0;
        calm = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && results_seen >= 600)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 499) == 0)
                    calm = !calm;
                if (!calm)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 15)
                        stall_left = $urandom_range(1, 3);
                    else if (pick < 18)
                        stall_left = $urandom_range(10, 40);
                end
            end
        end
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin
        line_out_t got;
        line_out_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            got = '{m_axis_tuser, m_axis_tdata[7:0], m_axis_tlast, m_axis_tdata[10:8],
                    m_axis_tdata[13:11], m_axis_tdata[21:14]};
            if (pending_lines.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected nothing, got %s", $time, show(got));
            end
            else
            begin
                want = pending_lines.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    $display("%0t: mismatch, expected %s, got %s",
                             $time, show(want), show(got));
                end
            end
        end
    end

    // Watchdog: too long without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
